/* hdl/epve_pkg.sv */
// Shared types and constants for the encoder period velocity estimator.
// Used by epve_ctrl, epve_dp and the top level; no dependencies.
package epve_pkg;

  localparam int IV_W   = 20;  // interval and limit width
  localparam int CNT_W  = 4;   // window and accepted-tick counters
  localparam int SUM_W  = 24;  // interval sum
  localparam int VEL_W  = 33;  // velocity, unsigned Q16
  localparam int NUM_W  = 40;  // dividend: scale * count, count <= 15
  localparam int DEN_W  = 28;  // divisor: sum * pulses per window, ppw <= 15
  localparam int STEP_W = 6;   // divider step counter
  localparam int ADDR_W = 2;
  localparam int DATA_W = IV_W;

  // 1e6 us/s in Q16
  localparam logic [NUM_W-1:0] VEL_SCALE = 40'd65536000000;
  localparam logic [VEL_W-1:0] VEL_MAX   = {VEL_W{1'b1}};

  localparam logic [IV_W-1:0] MIN_IV_RST = 20'd300;
  localparam logic [IV_W-1:0] MAX_IV_RST = 20'd3000;

  localparam logic [ADDR_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [ADDR_W-1:0] CFG_MIN_IV = 2'd1;
  localparam logic [ADDR_W-1:0] CFG_MAX_IV = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;     // accept the input request
    logic setup;    // load dividend and divisor
    logic step;     // one restoring division step
    logic publish;  // write quotient to velocity and output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic close_upd;  // current request closes a window with accepted ticks
    logic last_step;  // divider on its final step
    logic out_free;   // output register can be loaded this cycle
  } stat_t;

endpackage

/* hdl/encoder_period_velocity_estimator.sv */
// Top level of the encoder period velocity estimator.
// Depends on epve_pkg, epve_ctrl, epve_dp.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------
//  in      | in_interval_us[19:0], in_healthy        | in_valid / in_stall
//  out     | out_velocity_q16[32:0], out_updated     | out_valid / out_stall
//  cfg     | cfg_addr[1:0], cfg_wdata[19:0]          | cfg_we (no wait)
//
// Each request yields exactly one result. A request that does not close a
// window with accepted ticks loads a held result directly; one that does goes
// through setup, 40 restoring division steps of the 1 bit per cycle divider
// and publish. Reset (rst_n low, synchronous) restores enable=0, limits
// 300/3000 us, clears counters, sum and velocity. The input is stalled while
// the divider runs and whenever the output register holds a stalled result.
module encoder_period_velocity_estimator
  import epve_pkg::*;
#(
  parameter int PULSES_PER_WINDOW = 8  // 1..15
) (
  input  logic              clk,
  input  logic              rst_n,
  // config write port
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0] cfg_wdata,
  // tick event requests
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IV_W-1:0]   in_interval_us,
  input  logic              in_healthy,
  // velocity results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VEL_W-1:0]  out_velocity_q16,
  output logic              out_updated
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing: accept, divide, publish
  epve_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // accumulation, divider and output register
  epve_dp #(
    .PULSES_PER_WINDOW (PULSES_PER_WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_interval_us   (in_interval_us),
    .in_healthy       (in_healthy),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_velocity_q16 (out_velocity_q16),
    .out_updated      (out_updated)
  );

endmodule

/* hdl/epve_dp.sv */
// Datapath: config registers, window accumulation, bit-serial divider,
// output register. Depends on epve_pkg; driven by epve_ctrl commands.
module epve_dp
  import epve_pkg::*;
#(
  parameter int PULSES_PER_WINDOW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_addr,
  input  logic [DATA_W-1:0]   cfg_wdata,
  input  logic [IV_W-1:0]     in_interval_us,
  input  logic                in_healthy,
  input  logic                out_stall,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic                out_valid,
  output logic [VEL_W-1:0]    out_velocity_q16,
  output logic                out_updated
);

  localparam logic [CNT_W-1:0] PPW = CNT_W'(PULSES_PER_WINDOW);

  logic             enable_r;
  logic [IV_W-1:0]  min_iv_r, max_iv_r;
  logic [CNT_W-1:0] window_r, acc_r, cnt_hold_r;
  logic [SUM_W-1:0] sum_r, sum_hold_r;
  logic [VEL_W-1:0] vel_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [STEP_W-1:0] step_r;
  logic             out_valid_r, out_upd_r;
  logic [VEL_W-1:0] out_vel_r;

  logic [CNT_W-1:0] win_inc, acc_inc;
  logic [SUM_W-1:0] sum_inc;
  logic             hit, close, close_upd;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;
  logic [VEL_W-1:0] quo_sat;

  // per-request accumulation
  always_comb begin
    win_inc   = window_r + CNT_W'(1);
    hit       = in_healthy && (in_interval_us > min_iv_r) && (in_interval_us < max_iv_r);
    acc_inc   = hit ? acc_r + CNT_W'(1) : acc_r;
    sum_inc   = hit ? sum_r + SUM_W'(in_interval_us) : sum_r;
    close     = (win_inc >= PPW);
    close_upd = enable_r && close && (acc_inc != '0) && (sum_inc != '0);
  end

  // restoring division step
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    quo_sat = (num_r[NUM_W-1:VEL_W] != '0) ? VEL_MAX : num_r[VEL_W-1:0];
  end

  assign stat.close_upd = close_upd;
  assign stat.last_step = (step_r == STEP_W'(NUM_W - 1));
  assign stat.out_free  = !out_valid_r || !out_stall;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      min_iv_r <= MIN_IV_RST;
      max_iv_r <= MAX_IV_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        CFG_MIN_IV: min_iv_r <= cfg_wdata[IV_W-1:0];
        CFG_MAX_IV: max_iv_r <= cfg_wdata[IV_W-1:0];
        default: ;
      endcase
    end
  end

  // window state and held velocity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      acc_r    <= '0;
      sum_r    <= '0;
      vel_r    <= '0;
    end else begin
      if (cmd.take && enable_r) begin
        if (close) begin
          window_r <= '0;
          acc_r    <= '0;
          sum_r    <= '0;
        end else begin
          window_r <= win_inc;
          acc_r    <= acc_inc;
          sum_r    <= sum_inc;
        end
      end
      if (cmd.publish) vel_r <= quo_sat;
    end
  end

  // divider payload
  always_ff @(posedge clk) begin
    if (cmd.take && close_upd) begin
      cnt_hold_r <= acc_inc;
      sum_hold_r <= sum_inc;
    end
    if (cmd.setup) begin
      num_r  <= VEL_SCALE * NUM_W'(cnt_hold_r);
      den_r  <= DEN_W'(sum_hold_r) * DEN_W'(PULSES_PER_WINDOW);
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.step) begin
      num_r  <= {num_r[NUM_W-2:0], ge};
      rem_r  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish || (cmd.take && !close_upd)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_vel_r <= quo_sat;
      out_upd_r <= 1'b1;
    end else if (cmd.take && !close_upd) begin
      out_vel_r <= vel_r;
      out_upd_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_velocity_q16 = out_vel_r;
  assign out_updated      = out_upd_r;

  a_publish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r && out_upd_r)
    else $error("publish did not load an updated result");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && !close_upd |=> out_valid_r && !out_upd_r)
    else $error("plain request did not load a held result");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    window_r < PPW)
    else $error("window counter past window length");

endmodule

/* hdl/epve_ctrl.sv */
// Controller FSM: request acceptance, divider sequencing, result publish.
// Depends on epve_pkg; commands epve_dp.
module epve_ctrl
  import epve_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !stat.out_free;
        cmd.take = in_valid && stat.out_free;
        if (cmd.take && stat.close_upd) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (stat.last_step) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == ST_IDLE)
    else $error("request accepted outside idle");

  a_close_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && stat.close_upd |=> state_r == ST_SETUP)
    else $error("window close did not start division");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && stat.last_step |=> state_r == ST_DONE)
    else $error("divider did not finish");

endmodule
